// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/utf8d_pkg.sv
package utf8d_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CP_W       = 21;
  localparam int unsigned MAX_RES    = 4;
  localparam int unsigned RES_IDX_W  = 2;
  localparam int unsigned HOLD_DEPTH = 3;
  localparam int unsigned CONT_BITS  = 6;

  localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;
  localparam logic [2:0]        LEAD2_TAG = 3'h6;
  localparam logic [3:0]        LEAD3_TAG = 4'hE;
  localparam logic [4:0]        LEAD4_TAG = 5'h1E;

  typedef enum logic [2:0] {
    SEQ_IDLE = 3'd0,
    SEQ_LEN2 = 3'd2,
    SEQ_LEN3 = 3'd3,
    SEQ_LEN4 = 3'd4
  } seq_len_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_in;
    logic              end_of_string;
  } in_word_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            last_of_run;
    logic            string_done;
  } out_word_t;

  typedef struct packed {
    logic [MAX_RES-1:0][CP_W-1:0] cps;
    logic [RES_IDX_W-1:0]         last_idx;
    logic                         eos;
  } burst_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic logic [CP_W-1:0] zext_byte(input logic [BYTE_W-1:0] b);
    return {{(CP_W-BYTE_W){1'b0}}, b};
  endfunction

endpackage

// File: rtl/utf8d_front.sv
module utf8d_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  utf8d_pkg::in_word_t in_data,
  input  logic                full,
  output logic                push,
  output utf8d_pkg::burst_t   push_data
);

  logic [utf8d_pkg::BYTE_W-1:0] held_r   [utf8d_pkg::HOLD_DEPTH];
  logic [utf8d_pkg::BYTE_W-1:0] held_nxt [utf8d_pkg::HOLD_DEPTH];
  logic [1:0]                   held_cnt_r, held_cnt_nxt;
  utf8d_pkg::seq_len_t          seq_r, seq_nxt;
  logic [utf8d_pkg::CP_W-1:0]   part_r, part_nxt;

  logic                         accept;
  logic [utf8d_pkg::BYTE_W-1:0] b;
  logic                         eos;
  logic                         fresh;
  logic [2:0]                   n;
  logic [2:0]                   after;
  logic [utf8d_pkg::CP_W-1:0]   pv;
  logic [utf8d_pkg::CP_W-1:0]   cps [utf8d_pkg::MAX_RES];
  utf8d_pkg::seq_len_t          len;
  logic [utf8d_pkg::CP_W-1:0]   lead_bits;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  always_comb begin
    b     = in_data.byte_in;
    eos   = in_data.end_of_string;
    fresh = 1'b1;
    n     = 3'd0;
    after = {1'b0, held_cnt_r} + 3'd1;
    pv    = {part_r[utf8d_pkg::CP_W-utf8d_pkg::CONT_BITS-1:0], b[utf8d_pkg::CONT_BITS-1:0]};
    for (int k = 0; k < utf8d_pkg::MAX_RES; k++) begin
      cps[k] = '0;
    end
    for (int k = 0; k < utf8d_pkg::HOLD_DEPTH; k++) begin
      held_nxt[k] = held_r[k];
    end
    held_cnt_nxt = held_cnt_r;
    seq_nxt      = seq_r;
    part_nxt     = part_r;
    len          = utf8d_pkg::SEQ_IDLE;
    lead_bits    = '0;

    if (seq_r != utf8d_pkg::SEQ_IDLE) begin
      if ((b & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_TAG) begin
        fresh    = 1'b0;
        part_nxt = pv;
        if (after >= 3'(seq_r)) begin
          cps[0] = pv;
          n      = 3'd1;
          seq_nxt = utf8d_pkg::SEQ_IDLE;
        end else if (eos) begin
          for (int k = 0; k < utf8d_pkg::HOLD_DEPTH; k++) begin
            if (2'(k) < held_cnt_r) begin
              cps[k] = utf8d_pkg::zext_byte(held_r[k]);
            end
          end
          for (int k = 0; k < utf8d_pkg::MAX_RES; k++) begin
            if (3'(k) == {1'b0, held_cnt_r}) begin
              cps[k] = utf8d_pkg::zext_byte(b);
            end
          end
          n = after;
        end else if (held_cnt_r != 2'd3) begin
          held_nxt[held_cnt_r] = b;
          held_cnt_nxt         = after[1:0];
        end
      end else begin
        for (int k = 0; k < utf8d_pkg::HOLD_DEPTH; k++) begin
          if (2'(k) < held_cnt_r) begin
            cps[k] = utf8d_pkg::zext_byte(held_r[k]);
          end
        end
        n       = {1'b0, held_cnt_r};
        seq_nxt = utf8d_pkg::SEQ_IDLE;
      end
      if (seq_nxt == utf8d_pkg::SEQ_IDLE) begin
        for (int k = 0; k < utf8d_pkg::HOLD_DEPTH; k++) begin
          held_nxt[k] = '0;
        end
        held_cnt_nxt = 2'd0;
        part_nxt     = '0;
      end
    end

    if (fresh) begin
      priority if (!b[7]) begin
        len = utf8d_pkg::SEQ_IDLE;
      end else if (b[7:5] == utf8d_pkg::LEAD2_TAG) begin
        len       = utf8d_pkg::SEQ_LEN2;
        lead_bits = utf8d_pkg::CP_W'(b[4:0]);
      end else if (b[7:4] == utf8d_pkg::LEAD3_TAG) begin
        len       = utf8d_pkg::SEQ_LEN3;
        lead_bits = utf8d_pkg::CP_W'(b[3:0]);
      end else if (b[7:3] == utf8d_pkg::LEAD4_TAG) begin
        len       = utf8d_pkg::SEQ_LEN4;
        lead_bits = utf8d_pkg::CP_W'(b[2:0]);
      end else begin
        len = utf8d_pkg::SEQ_IDLE;
      end
      if (len == utf8d_pkg::SEQ_IDLE || eos) begin
        for (int k = 0; k < utf8d_pkg::MAX_RES; k++) begin
          if (3'(k) == n) begin
            cps[k] = utf8d_pkg::zext_byte(b);
          end
        end
        n = n + 3'd1;
      end else begin
        held_nxt[0]  = b;
        held_nxt[1]  = '0;
        held_nxt[2]  = '0;
        held_cnt_nxt = 2'd1;
        seq_nxt      = len;
        part_nxt     = lead_bits;
      end
    end

    if (eos) begin
      for (int k = 0; k < utf8d_pkg::HOLD_DEPTH; k++) begin
        held_nxt[k] = '0;
      end
      held_cnt_nxt = 2'd0;
      seq_nxt      = utf8d_pkg::SEQ_IDLE;
      part_nxt     = '0;
    end
  end

  always_comb begin
    push               = accept && (n != 3'd0);
    push_data.last_idx = utf8d_pkg::RES_IDX_W'(n - 3'd1);
    push_data.eos      = eos;
    for (int k = 0; k < utf8d_pkg::MAX_RES; k++) begin
      push_data.cps[k] = cps[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < utf8d_pkg::HOLD_DEPTH; k++) begin
        held_r[k] <= '0;
      end
      held_cnt_r <= 2'd0;
      seq_r      <= utf8d_pkg::SEQ_IDLE;
      part_r     <= '0;
    end else if (accept) begin
      for (int k = 0; k < utf8d_pkg::HOLD_DEPTH; k++) begin
        held_r[k] <= held_nxt[k];
      end
      held_cnt_r <= held_cnt_nxt;
      seq_r      <= seq_nxt;
      part_r     <= part_nxt;
    end
  end

endmodule

// File: rtl/utf8d_fifo.sv
module utf8d_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  utf8d_pkg::burst_t      push_data,
  input  logic                   pop,
  output utf8d_pkg::burst_t      head,
  output utf8d_pkg::fifo_status_t status
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  utf8d_pkg::burst_t mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]       count_r, count_nxt;
  logic              do_push, do_pop;

  assign status.full  = (count_r == (AW+1)'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: rtl/utf8d_back.sv
module utf8d_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  utf8d_pkg::burst_t         head,
  input  utf8d_pkg::fifo_status_t   status,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output utf8d_pkg::out_word_t      out_data
);

  logic [utf8d_pkg::RES_IDX_W-1:0] idx_r, idx_nxt;
  logic                            is_last;
  logic                            take;

  assign out_valid = !status.empty;
  assign is_last   = (idx_r == head.last_idx);
  assign take      = out_valid && !out_stall;
  assign pop       = take && is_last;

  assign out_data.code_point  = head.cps[idx_r];
  assign out_data.last_of_run = is_last;
  assign out_data.string_done = is_last && head.eos;

  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = is_last ? '0 : idx_r + utf8d_pkg::RES_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

// File: rtl/utf8_stream_decoder.sv
// Each taken byte puts its results, if any, into the queue as one entry.
// The decoder takes one byte per cycle while the queue is not full; the
// output side sends one word per cycle unless stalled, one word per result.
// A queue of FIFO_DEPTH byte results decouples the decoder from the output.
// Reset (rst_n low, synchronous) empties the queue and leaves the decoder idle.
module utf8_stream_decoder #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  utf8d_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output utf8d_pkg::out_word_t out_data
);

  logic                    push;
  logic                    pop;
  utf8d_pkg::burst_t       push_data;
  utf8d_pkg::burst_t       head;
  utf8d_pkg::fifo_status_t status;

  utf8d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .full      (status.full),
    .push      (push),
    .push_data (push_data)
  );

  utf8d_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (status)
  );

  utf8d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .status    (status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/utf8d_checker.sv
`include "assert_macros.svh"

module utf8d_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input utf8d_pkg::out_word_t out_data
);

  `ASSERT_ALWAYS(a_idle_after_reset, !rst_n |=> !out_valid, "output word valid right after reset")
  `ASSERT_CLK(a_done_is_last, out_valid && out_data.string_done |-> out_data.last_of_run, "string end not on last word of its byte")
  `ASSERT_CLK(a_wide_cp_alone, out_valid && (out_data.code_point[20:8] != '0) |-> out_data.last_of_run, "decoded code point shares its byte with other words")
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled output word changed")

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: sim/utf8_stream_decoder_tb.sv
`timescale 1ns / 100ps

module utf8_stream_decoder_tb;

  typedef struct packed {
    utf8d_pkg::in_word_t        w;
    logic                       known;
    logic [utf8d_pkg::CP_W-1:0] cp;
  } stim_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  utf8d_pkg::in_word_t  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  utf8d_pkg::out_word_t out_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int bytes_taken    = 0;
  int words_seen     = 0;
  int strings_sent   = 0;

  // Decoder state as the predictor sees it.
  logic [utf8d_pkg::BYTE_W-1:0] held [utf8d_pkg::HOLD_DEPTH];
  int                           held_cnt;
  utf8d_pkg::seq_len_t          seq_len;
  logic [utf8d_pkg::CP_W-1:0]   partial;

  utf8d_pkg::out_word_t burst_cps [$];
  utf8d_pkg::out_word_t pending_cps [$];
  stim_t                stim_q [$];
  stim_t                cur_stim = '0;
  stim_t                directed_tbl [24];
  utf8d_pkg::out_word_t want_w;
  utf8d_pkg::out_word_t typed_w;

  utf8_stream_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic report_mismatch(input string what,
                                 input logic [utf8d_pkg::CP_W-1:0] got,
                                 input logic [utf8d_pkg::CP_W-1:0] want);
    $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void clear_held();
    held[0]  = '0;
    held[1]  = '0;
    held[2]  = '0;
    held_cnt = 0;
    seq_len  = utf8d_pkg::SEQ_IDLE;
    partial  = '0;
  endfunction

  function automatic void emit_cp(input logic [utf8d_pkg::CP_W-1:0] cp);
    utf8d_pkg::out_word_t r;
    r = '0;
    r.code_point = cp;
    if (burst_cps.size() < utf8d_pkg::MAX_RES) burst_cps = {burst_cps, r};
  endfunction

  function automatic void flush_held();
    for (int k = 0; k < held_cnt; k++) emit_cp(utf8d_pkg::zext_byte(held[k]));
    clear_held();
  endfunction

  function automatic void decode_byte(input utf8d_pkg::in_word_t w);
    logic [utf8d_pkg::BYTE_W-1:0] b;
    logic                         eos;
    logic                         fresh;
    utf8d_pkg::seq_len_t          lead_len;
    logic [utf8d_pkg::CP_W-1:0]   lead_bits;
    b     = w.byte_in;
    eos   = w.end_of_string;
    fresh = 1'b1;
    burst_cps.delete();
    if (seq_len != utf8d_pkg::SEQ_IDLE) begin
      if ((b & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_TAG) begin
        fresh   = 1'b0;
        partial = {partial[utf8d_pkg::CP_W-utf8d_pkg::CONT_BITS-1:0],
                   b[utf8d_pkg::CONT_BITS-1:0]};
        if (held_cnt + 1 >= int'(seq_len)) begin
          emit_cp(partial);
          clear_held();
        end else if (eos) begin
          flush_held();
          emit_cp(utf8d_pkg::zext_byte(b));
        end else begin
          held[held_cnt] = b;
          held_cnt++;
        end
      end else begin
        flush_held();
      end
    end
    if (fresh) begin
      lead_len  = utf8d_pkg::SEQ_IDLE;
      lead_bits = '0;
      if (b[7:5] == utf8d_pkg::LEAD2_TAG) begin
        lead_len  = utf8d_pkg::SEQ_LEN2;
        lead_bits = utf8d_pkg::CP_W'(b[4:0]);
      end else if (b[7:4] == utf8d_pkg::LEAD3_TAG) begin
        lead_len  = utf8d_pkg::SEQ_LEN3;
        lead_bits = utf8d_pkg::CP_W'(b[3:0]);
      end else if (b[7:3] == utf8d_pkg::LEAD4_TAG) begin
        lead_len  = utf8d_pkg::SEQ_LEN4;
        lead_bits = utf8d_pkg::CP_W'(b[2:0]);
      end
      if (lead_len == utf8d_pkg::SEQ_IDLE || eos) begin
        emit_cp(utf8d_pkg::zext_byte(b));
      end else begin
        held[0]  = b;
        held[1]  = '0;
        held[2]  = '0;
        held_cnt = 1;
        seq_len  = lead_len;
        partial  = lead_bits;
      end
    end
    if (eos) clear_held();
    if (burst_cps.size() > 0) begin
      burst_cps[burst_cps.size()-1].last_of_run = 1'b1;
      burst_cps[burst_cps.size()-1].string_done = eos;
    end
  endfunction

  // Builds one string, mostly well-formed characters, with noise bytes and
  // cut-short sequences mixed in.
  function automatic int add_random_string();
    int                           n_chars;
    int                           cls;
    int                           nb;
    int                           keep;
    logic [utf8d_pkg::CP_W-1:0]   r;
    logic [utf8d_pkg::BYTE_W-1:0] seq [4];
    stim_t                        s;
    int                           added;
    added   = 0;
    n_chars = $urandom_range(1, 8);
    for (int c = 0; c < n_chars; c++) begin
      cls = $urandom_range(99);
      r   = utf8d_pkg::CP_W'($urandom);
      if (cls < 40) begin
        nb     = 1;
        seq[0] = {1'b0, r[6:0]};
      end else if (cls < 60) begin
        nb     = 2;
        seq[0] = {3'b110, r[10:6]};
        seq[1] = {2'b10, r[5:0]};
      end else if (cls < 75) begin
        nb     = 3;
        seq[0] = {4'b1110, r[15:12]};
        seq[1] = {2'b10, r[11:6]};
        seq[2] = {2'b10, r[5:0]};
      end else if (cls < 90) begin
        nb     = 4;
        seq[0] = {5'b11110, r[20:18]};
        seq[1] = {2'b10, r[17:12]};
        seq[2] = {2'b10, r[11:6]};
        seq[3] = {2'b10, r[5:0]};
      end else begin
        nb     = 1;
        seq[0] = r[7:0];
      end
      keep = nb;
      if (nb > 1 && $urandom_range(99) < 15) keep = $urandom_range(1, nb - 1);
      for (int k = 0; k < keep; k++) begin
        s = '0;
        s.w.byte_in = seq[k];
        stim_q = {stim_q, s};
        added++;
      end
    end
    stim_q[stim_q.size()-1].w.end_of_string = 1'b1;
    strings_sent++;
    return added;
  endfunction

  task automatic send_word(input stim_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    cur_stim = s;
    in_data  = s.w;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_queued();
    while (stim_q.size() > 0) send_word(stim_q.pop_front());
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_cps.size() != 0) @(negedge clk);
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct, input int n_bytes);
    int made;
    made           = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (made < n_bytes) made += add_random_string();
    send_queued();
    drain_results();
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        decode_byte(in_data);
        bytes_taken++;
        if (cur_stim.known) begin
          typed_w             = '0;
          typed_w.code_point  = cur_stim.cp;
          typed_w.last_of_run = 1'b1;
          typed_w.string_done = in_data.end_of_string;
          pending_cps = {pending_cps, typed_w};
        end else begin
          foreach (burst_cps[i]) pending_cps = {pending_cps, burst_cps[i]};
        end
      end
      if (out_valid && !out_stall) begin
        words_seen++;
        if (pending_cps.size() == 0) begin
          report_mismatch("result word with none expected", out_data.code_point, '0);
        end else begin
          want_w = pending_cps.pop_front();
          if (out_data.code_point != want_w.code_point)
            report_mismatch("code_point", out_data.code_point, want_w.code_point);
          if (out_data.last_of_run != want_w.last_of_run)
            report_mismatch("last_of_run", utf8d_pkg::CP_W'(out_data.last_of_run),
                            utf8d_pkg::CP_W'(want_w.last_of_run));
          if (out_data.string_done != want_w.string_done)
            report_mismatch("string_done", utf8d_pkg::CP_W'(out_data.string_done),
                            utf8d_pkg::CP_W'(want_w.string_done));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d result words outstanding.", pending_cps.size());
    $display("** utf8_stream_decoder: FAILED **");
    $finish;
  end

  initial begin
    clear_held();
    directed_tbl = '{
      '{'{8'h00, 1'b0}, 1'b1, 21'h000000},
      '{'{8'h7F, 1'b0}, 1'b1, 21'h00007F},
      '{'{8'h80, 1'b0}, 1'b1, 21'h000080},
      '{'{8'hFF, 1'b0}, 1'b1, 21'h0000FF},
      '{'{8'hC3, 1'b0}, 1'b0, 21'h000000},
      '{'{8'hA9, 1'b0}, 1'b1, 21'h0000E9},
      '{'{8'hF7, 1'b0}, 1'b0, 21'h000000},
      '{'{8'hBF, 1'b0}, 1'b0, 21'h000000},
      '{'{8'hBF, 1'b0}, 1'b0, 21'h000000},
      '{'{8'hBF, 1'b0}, 1'b1, 21'h1FFFFF},
      '{'{8'hED, 1'b0}, 1'b0, 21'h000000},
      '{'{8'hA0, 1'b0}, 1'b0, 21'h000000},
      '{'{8'h80, 1'b0}, 1'b1, 21'h00D800},
      '{'{8'hF0, 1'b0}, 1'b0, 21'h000000},
      '{'{8'h9F, 1'b0}, 1'b0, 21'h000000},
      '{'{8'h98, 1'b0}, 1'b0, 21'h000000},
      '{'{8'hE2, 1'b0}, 1'b0, 21'h000000},
      '{'{8'h41, 1'b0}, 1'b0, 21'h000000},
      '{'{8'hC0, 1'b0}, 1'b0, 21'h000000},
      '{'{8'h80, 1'b1}, 1'b1, 21'h000000},
      '{'{8'hE2, 1'b0}, 1'b0, 21'h000000},
      '{'{8'h82, 1'b1}, 1'b0, 21'h000000},
      '{'{8'hF0, 1'b1}, 1'b1, 21'h0000F0},
      '{'{8'h41, 1'b1}, 1'b1, 21'h000041}
    };
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct  = 6;
    recv_stall_pct = 52;
    foreach (directed_tbl[i]) begin
      stim_q = {stim_q, directed_tbl[i]};
      if (directed_tbl[i].w.end_of_string) strings_sent++;
    end
    send_queued();
    drain_results();
    random_phase(6, 52, 22);
    random_phase(52, 6, 22);
    random_phase(0, 0, 22);

    repeat (8) @(posedge clk);
    foreach (pending_cps[i])
      report_mismatch("result word never produced", '0, pending_cps[i].code_point);
    $display("Decoded %0d bytes in %0d strings into %0d result words, %0d mismatches.",
             bytes_taken, strings_sent, words_seen, mismatches);
    $display("Stress covered sender gaps, receiver back-pressure, both and neither.");
    if (mismatches == 0) begin
      $display("** utf8_stream_decoder: PASSED **");
    end else begin
      $display("** utf8_stream_decoder: FAILED **");
    end
    $finish;
  end

endmodule
